@@ rtl/sara_pkg.sv @@
// Shared types, constants and helper functions for the shelf atlas allocator.
// Used by sara_ctrl, sara_dpath, sara_checker and the top level.
// Depends on nothing.
`default_nettype none

package sara_pkg;

    localparam int CALC_W    = 17;   // holds padded sizes and side sums
    localparam int FIELD_W   = 15;
    localparam int PAD_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 96;
    localparam int M_USED_W  = 6 * FIELD_W + 1;
    localparam int GREW_BIT  = 6 * FIELD_W;

    localparam logic [PAD_W-1:0]   PAD_RESET  = 4'd1;
    localparam logic [FIELD_W-1:0] INIT_RESET = 15'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PAD,
        ST_CHECK,
        ST_GROW_W_CALC,
        ST_GROW_W_APPLY,
        ST_SHELF,
        ST_HEIGHT_CHECK,
        ST_GROW_H_CALC,
        ST_GROW_H_APPLY,
        ST_COMMIT,
        ST_FAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic fail;
        logic pad;
        logic chk;
        logic grow_calc;
        logic grow_tall;
        logic grow_apply;
        logic shelf;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic chk_fail;
        logic need_grow_w;
        logic grow_fail;
        logic need_grow_h;
        logic out_free;
    } dp_status_t;

    function automatic logic [CALC_W-1:0] umax(input logic [CALC_W-1:0] a,
                                               input logic [CALC_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Smallest power of two >= v (1 for v of 0 or 1); zero when v is above lim,
    // lim being the first power of two at or above the side limit.
    function automatic logic [CALC_W-1:0] round_pow2(input logic [CALC_W-1:0] v,
                                                     input logic [CALC_W-1:0] lim);
        logic [CALC_W-1:0] r;
        r = CALC_W'(1);
        for (int i = 0; i < CALC_W - 1; i++) begin
            if (v > (CALC_W'(1) << i)) begin
                r = CALC_W'(1) << (i + 1);
            end
        end
        if (v > lim) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sara_ctrl.sv @@
// Sequencing state machine for the shelf atlas allocator.
// Drives datapath commands from datapath status; uses sara_pkg.
`default_nettype none

module sara_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output sara_pkg::dp_cmd_t         cmd,
    input  wire sara_pkg::dp_status_t status
);
    import sara_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.in_clear ? ST_CLEAR : ST_PAD;
                end
            end
            ST_CLEAR:        state_next = ST_DONE;
            ST_PAD:          state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.chk_fail)
                begin
                    state_next = ST_FAIL;
                end
                else if (status.need_grow_w)
                begin
                    state_next = ST_GROW_W_CALC;
                end
                else
                begin
                    state_next = ST_SHELF;
                end
            end
            ST_GROW_W_CALC:  state_next = ST_GROW_W_APPLY;
            ST_GROW_W_APPLY: state_next = status.grow_fail ? ST_FAIL : ST_SHELF;
            ST_SHELF:        state_next = ST_HEIGHT_CHECK;
            ST_HEIGHT_CHECK: state_next = status.need_grow_h ? ST_GROW_H_CALC : ST_COMMIT;
            ST_GROW_H_CALC:  state_next = ST_GROW_H_APPLY;
            ST_GROW_H_APPLY: state_next = status.grow_fail ? ST_FAIL : ST_COMMIT;
            ST_COMMIT:       state_next = ST_DONE;
            ST_FAIL:         state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:         state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CLEAR:        cmd.clear = 1'b1;
            ST_PAD:          cmd.pad = 1'b1;
            ST_CHECK:        cmd.chk = 1'b1;
            ST_GROW_W_CALC:  cmd.grow_calc = 1'b1;
            ST_GROW_W_APPLY: cmd.grow_apply = 1'b1;
            ST_SHELF:        cmd.shelf = 1'b1;
            ST_HEIGHT_CHECK: cmd = '0;
            ST_GROW_H_CALC:
            begin
                cmd.grow_calc = 1'b1;
                cmd.grow_tall = 1'b1;
            end
            ST_GROW_H_APPLY: cmd.grow_apply = 1'b1;
            ST_COMMIT:       cmd.commit = 1'b1;
            ST_FAIL:         cmd.fail = 1'b1;
            ST_DONE:         cmd.out_load = status.out_free;
            default:         cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sara_dpath.sv @@
// Datapath of the shelf atlas allocator: config registers, atlas state,
// grow unit, shelf logic and the result register. Uses sara_pkg.
`default_nettype none

module sara_dpath #(
    parameter int MAX_SIDE = 16384
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sara_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sara_pkg::FIELD_W-1:0]    cfg_wdata,
    input  wire logic [sara_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sara_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                           m_tuser,
    input  wire sara_pkg::dp_cmd_t               cmd,
    output sara_pkg::dp_status_t                 status
);
    import sara_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE) + 1;
    localparam int LIM    = 1 << $clog2(MAX_SIDE);
    localparam logic [CALC_W-1:0] MAX_C = CALC_W'(MAX_SIDE);
    localparam logic [CALC_W-1:0] LIM_C = CALC_W'(LIM);

    // configuration
    logic [PAD_W-1:0]   pad_reg;
    logic [FIELD_W-1:0] init_reg;

    // item being worked on
    logic               op_reg;
    logic [FIELD_W-1:0] w_reg;
    logic [FIELD_W-1:0] h_reg;
    logic [SIDE_W-1:0]  old_aw_reg;
    logic [SIDE_W-1:0]  old_ah_reg;
    logic [CALC_W-1:0]  rw_reg;
    logic [CALC_W-1:0]  rh_reg;
    logic [CALC_W-1:0]  want_w_reg;
    logic [CALC_W-1:0]  nw_reg;
    logic [CALC_W-1:0]  nh_reg;
    logic               gfail_reg;
    logic               keep_reg;
    logic               ok_reg;
    logic [FIELD_W-1:0] px_reg;
    logic [FIELD_W-1:0] py_reg;

    // atlas state
    logic [SIDE_W-1:0]  aw_reg;
    logic [SIDE_W-1:0]  ah_reg;
    logic [SIDE_W-1:0]  cur_reg;
    logic [SIDE_W-1:0]  shelf_y_reg;
    logic [SIDE_W-1:0]  shelf_h_reg;
    logic [SIDE_W-1:0]  used_w_reg;
    logic [SIDE_W-1:0]  used_h_reg;

    // result register
    logic                 res_valid_reg;
    logic                 res_ok_reg;
    logic [M_TDATA_W-1:0] res_data_reg;

    logic [CALC_W-1:0] aw_x;
    logic [CALC_W-1:0] ah_x;
    logic [CALC_W-1:0] init_x;
    logic [CALC_W-1:0] pad_x;
    logic [CALC_W-1:0] base_w;
    logic [CALC_W-1:0] want_w;
    logic [CALC_W-1:0] fit_sum;
    logic [CALC_W-1:0] tall_sum;
    logic [CALC_W-1:0] g_ww;
    logic [CALC_W-1:0] g_wh;
    logic [CALC_W-1:0] g_bw;
    logic [CALC_W-1:0] g_bh;
    logic [CALC_W-1:0] g_nw;
    logic [CALC_W-1:0] g_nh;
    logic              grew;

    assign aw_x   = CALC_W'(aw_reg);
    assign ah_x   = CALC_W'(ah_reg);
    assign init_x = CALC_W'(init_reg);
    assign pad_x  = CALC_W'(pad_reg);

    assign base_w   = (aw_reg == '0) ? init_x : aw_x;
    assign want_w   = round_pow2(umax(base_w, rw_reg), LIM_C);
    assign fit_sum  = CALC_W'(cur_reg) + rw_reg;
    assign tall_sum = CALC_W'(shelf_y_reg) + rh_reg;

    // grow operands: first box, wide box, or tall box
    always_comb
    begin
        if (cmd.grow_tall)
        begin
            g_ww = aw_x;
            g_wh = tall_sum;
        end
        else
        begin
            g_ww = want_w_reg;
            g_wh = (aw_reg == '0) ? umax(rh_reg, init_x) : ah_x;
        end
    end

    assign g_bw = (aw_reg == '0) ? init_x : aw_x;
    assign g_bh = (ah_reg == '0) ? init_x : ah_x;
    assign g_nw = round_pow2(umax(g_bw, g_ww), LIM_C);
    assign g_nh = round_pow2(umax(g_bh, g_wh), LIM_C);

    assign status.in_clear    = (s_tuser[0] == OP_CLEAR);
    assign status.chk_fail    = (rw_reg == '0) || (rh_reg == '0) || (rw_reg > MAX_C)
                                || (rh_reg > MAX_C) || (want_w == '0);
    assign status.need_grow_w = (aw_reg == '0) || (rw_reg > aw_x);
    assign status.grow_fail   = gfail_reg;
    assign status.need_grow_h = tall_sum > ah_x;
    assign status.out_free    = !res_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg  <= PAD_RESET;
            init_reg <= INIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAD:  pad_reg <= cfg_wdata[PAD_W-1:0];
                CFG_INIT: init_reg <= cfg_wdata;
                default:  pad_reg <= pad_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= s_tuser[0];
            w_reg      <= s_tdata[FIELD_W-1:0];
            h_reg      <= s_tdata[2*FIELD_W-1:FIELD_W];
            old_aw_reg <= aw_reg;
            old_ah_reg <= ah_reg;
        end
        if (cmd.pad)
        begin
            rw_reg <= CALC_W'(w_reg) + (pad_x << 1);
            rh_reg <= CALC_W'(h_reg) + (pad_x << 1);
        end
        if (cmd.chk)
        begin
            want_w_reg <= want_w;
        end
        if (cmd.grow_calc)
        begin
            nw_reg    <= g_nw;
            nh_reg    <= g_nh;
            gfail_reg <= (g_ww > MAX_C) || (g_wh > MAX_C) || (g_nw == '0) || (g_nh == '0);
            keep_reg  <= (aw_reg != '0) && (aw_x >= g_nw) && (ah_x >= g_nh);
        end
        if (cmd.clear)
        begin
            ok_reg <= 1'b1;
            px_reg <= '0;
            py_reg <= '0;
        end
        else if (cmd.fail)
        begin
            ok_reg <= 1'b0;
            px_reg <= '0;
            py_reg <= '0;
        end
        else if (cmd.commit)
        begin
            ok_reg <= 1'b1;
            px_reg <= FIELD_W'(CALC_W'(cur_reg) + pad_x);
            py_reg <= FIELD_W'(CALC_W'(shelf_y_reg) + pad_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg      <= '0;
            ah_reg      <= '0;
            cur_reg     <= '0;
            shelf_y_reg <= '0;
            shelf_h_reg <= '0;
            used_w_reg  <= '0;
            used_h_reg  <= '0;
        end
        else if (cmd.clear || cmd.fail)
        begin
            aw_reg      <= '0;
            ah_reg      <= '0;
            cur_reg     <= '0;
            shelf_y_reg <= '0;
            shelf_h_reg <= '0;
            used_w_reg  <= '0;
            used_h_reg  <= '0;
        end
        else if (cmd.grow_apply)
        begin
            if (!gfail_reg && !keep_reg)
            begin
                aw_reg <= SIDE_W'(nw_reg);
                ah_reg <= SIDE_W'(nh_reg);
            end
        end
        else if (cmd.shelf)
        begin
            // box does not fit the rest of the row: open a new shelf
            if (fit_sum > aw_x)
            begin
                cur_reg     <= '0;
                shelf_y_reg <= shelf_y_reg + shelf_h_reg;
                shelf_h_reg <= '0;
            end
        end
        else if (cmd.commit)
        begin
            cur_reg     <= SIDE_W'(fit_sum);
            shelf_h_reg <= SIDE_W'(umax(CALC_W'(shelf_h_reg), rh_reg));
            used_w_reg  <= SIDE_W'(umax(CALC_W'(used_w_reg), fit_sum));
            used_h_reg  <= SIDE_W'(umax(CALC_W'(used_h_reg), tall_sum));
        end
    end

    assign grew = ok_reg && (op_reg == OP_ALLOC)
                  && ((aw_reg != old_aw_reg) || (ah_reg != old_ah_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_ok_reg   <= ok_reg;
            res_data_reg <= {{(M_TDATA_W - M_USED_W){1'b0}},
                             grew,
                             FIELD_W'(used_h_reg),
                             FIELD_W'(used_w_reg),
                             FIELD_W'(ah_reg),
                             FIELD_W'(aw_reg),
                             py_reg,
                             px_reg};
        end
    end

    assign m_tvalid   = res_valid_reg;
    assign m_tdata    = res_data_reg;
    assign m_tuser[0] = res_ok_reg;

endmodule

`default_nettype wire

@@ rtl/shelf_atlas_rect_allocator.sv @@
// Shelf next-fit rectangle allocator for a growable power-of-two atlas.
// Top level: joins sara_ctrl and sara_dpath; uses sara_pkg.
//
// Input stream (s_*): one transfer per request. s_tuser[0] is the opcode
// (allocate or clear); s_tdata carries the rectangle width and height.
// Output stream (m_*): exactly one transfer per request. m_tuser[0] is ok;
// m_tdata carries the content position, atlas size, used extent and a grew
// flag. A failed allocate answers ok low with all fields zero and empties
// the atlas.
// Config port: cfg_we/cfg_index/cfg_wdata write pad width (index 0) or the
// initial side (index 1); write only while the block is idle.
// Timing: one request is worked on at a time by the state machine. A clear
// goes from accept to the done state; an allocate steps through pad, check,
// an optional width grow, shelf, height check, an optional height grow and
// commit, or goes to the fail state when the padded box is rejected early or a
// grow fails. The result appears on m_tvalid in the same cycle that s_tready returns.
// A stalled receiver holds the result in the output register; the next
// request is accepted meanwhile and waits in its final state for the slot.
// Reset empties the atlas, sets pad width 1 and initial side 1024.
`default_nettype none

module shelf_atlas_rect_allocator #(
    parameter int MAX_SIDE = 16384
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config write port
    input  wire logic                            cfg_we,
    input  wire logic [sara_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sara_pkg::FIELD_W-1:0]    cfg_wdata,
    // request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sara_pkg::S_TDATA_W-1:0]  s_tdata,   // rect_width, rect_height
    input  wire logic [0:0]                      s_tuser,   // opcode
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sara_pkg::M_TDATA_W-1:0]       m_tdata,   // pos_x, pos_y, atlas_w,
                                                            // atlas_h, extent_w,
                                                            // extent_h, grew
    output logic [0:0]                           m_tuser    // ok
);
    import sara_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sara_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sara_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ rtl/sara_checker.sv @@
// Port-level checks for the shelf atlas allocator, bound to the top level.
// Uses sara_pkg for field layout.
`default_nettype none

module sara_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [sara_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire logic [0:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sara_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]                      m_tuser
);
    import sara_pkg::*;

    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a failure reports an empty atlas and no position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("failure result carries data");

    a_grew_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[GREW_BIT] |-> m_tuser[0])
        else $error("grew set on failed result");

endmodule

bind shelf_atlas_rect_allocator sara_checker u_sara_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for shelf_atlas_rect_allocator: directed and random allocate/clear traffic,
// with random stalls on both streams, checked against a shelf-packing scoreboard.
// Depends on rtl/sara_pkg.sv and rtl/shelf_atlas_rect_allocator.sv.
`timescale 1ns / 100ps

module testbench;
    import sara_pkg::*;

    localparam int ATLAS_MAX = 16384;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 320;

    typedef struct {
        logic               op;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
    } request_t;

    typedef struct {
        logic               ok;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] atlas_w;
        logic [FIELD_W-1:0] atlas_h;
        logic [FIELD_W-1:0] extent_w;
        logic [FIELD_W-1:0] extent_h;
        logic               grew;
    } placement_t;

    // Tracks the atlas as the block should see it and queues the expected answers.
    class shelf_tracker;
        int unsigned pad;
        int unsigned init_side;
        int unsigned aw;
        int unsigned ah;
        int unsigned cur_x;
        int unsigned shelf_top;
        int unsigned shelf_tall;
        int unsigned used_w;
        int unsigned used_h;
        placement_t  answers_q[$];
        int          faults;

        function new();
            pad       = 1;
            init_side = 1024;
            faults    = 0;
            wipe();
        endfunction

        function void wipe();
            aw         = 0;
            ah         = 0;
            cur_x      = 0;
            shelf_top  = 0;
            shelf_tall = 0;
            used_w     = 0;
            used_h     = 0;
        endfunction

        function void set_regs(int unsigned p, int unsigned s);
            pad       = p;
            init_side = s;
        endfunction

        function int pending();
            return answers_q.size();
        endfunction

        function int unsigned bigger(int unsigned a, int unsigned b);
            return (a > b) ? a : b;
        endfunction

        // power-of-two round-up capped at the side limit; 0 when it cannot reach v
        function int unsigned pow2_ceil(int unsigned v);
            int unsigned r;
            r = 1;
            while (r < v && r < ATLAS_MAX)
                r = r << 1;
            return (r >= v) ? r : 0;
        endfunction

        function bit grow_sides(int unsigned want_w, int unsigned want_h);
            int unsigned nw;
            int unsigned nh;
            if (want_w > ATLAS_MAX || want_h > ATLAS_MAX)
                return 1'b0;
            nw = pow2_ceil(bigger((aw != 0) ? aw : init_side, want_w));
            nh = pow2_ceil(bigger((ah != 0) ? ah : init_side, want_h));
            if (nw == 0 || nh == 0)
                return 1'b0;
            if (aw != 0 && aw >= nw && ah >= nh)
                return 1'b1;
            aw = nw;
            ah = nh;
            return 1'b1;
        endfunction

        function bit place_box(int unsigned w, int unsigned h,
                               output int unsigned px, output int unsigned py);
            int unsigned rw;
            int unsigned rh;
            int unsigned want_w;
            px = 0;
            py = 0;
            rw = w + 2 * pad;
            rh = h + 2 * pad;
            if (rw == 0 || rh == 0 || rw > ATLAS_MAX || rh > ATLAS_MAX)
                return 1'b0;
            want_w = pow2_ceil(bigger((aw != 0) ? aw : init_side, rw));
            if (want_w == 0)
                return 1'b0;
            if (aw == 0)
            begin
                if (!grow_sides(want_w, bigger(rh, init_side)))
                    return 1'b0;
            end
            else if (rw > aw)
            begin
                // wide box: widen first, height kept
                if (!grow_sides(want_w, ah))
                    return 1'b0;
            end
            if (cur_x + rw > aw)
            begin
                cur_x      = 0;
                shelf_top  = shelf_top + shelf_tall;
                shelf_tall = 0;
            end
            if (shelf_top + rh > ah && !grow_sides(aw, shelf_top + rh))
                return 1'b0;
            px         = cur_x + pad;
            py         = shelf_top + pad;
            cur_x      = cur_x + rw;
            shelf_tall = bigger(shelf_tall, rh);
            used_w     = bigger(used_w, cur_x);
            used_h     = bigger(used_h, shelf_top + rh);
            return 1'b1;
        endfunction

        function void log_request(logic op, int unsigned w, int unsigned h);
            placement_t  e;
            int unsigned old_w;
            int unsigned old_h;
            int unsigned px;
            int unsigned py;
            bit          ok;
            old_w = aw;
            old_h = ah;
            px    = 0;
            py    = 0;
            if (op == OP_CLEAR)
            begin
                wipe();
                ok = 1'b1;
            end
            else
            begin
                ok = place_box(w, h, px, py);
                if (!ok)
                begin
                    wipe();
                    px = 0;
                    py = 0;
                end
            end
            e.ok       = ok;
            e.pos_x    = px[FIELD_W-1:0];
            e.pos_y    = py[FIELD_W-1:0];
            e.atlas_w  = aw[FIELD_W-1:0];
            e.atlas_h  = ah[FIELD_W-1:0];
            e.extent_w = used_w[FIELD_W-1:0];
            e.extent_h = used_h[FIELD_W-1:0];
            e.grew     = ok && op == OP_ALLOC && (aw != old_w || ah != old_h);
            answers_q.push_back(e);
        endfunction

        function void match(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                faults++;
            end
        endfunction

        function void verify_result(logic ok, logic [M_TDATA_W-1:0] d);
            placement_t e;
            if (answers_q.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                faults++;
                return;
            end
            e = answers_q.pop_front();
            match("ok", e.ok, ok);
            match("pos_x", e.pos_x, d[FIELD_W-1:0]);
            match("pos_y", e.pos_y, d[2*FIELD_W-1:FIELD_W]);
            match("atlas_w", e.atlas_w, d[3*FIELD_W-1:2*FIELD_W]);
            match("atlas_h", e.atlas_h, d[4*FIELD_W-1:3*FIELD_W]);
            match("extent_w", e.extent_w, d[5*FIELD_W-1:4*FIELD_W]);
            match("extent_h", e.extent_h, d[6*FIELD_W-1:5*FIELD_W]);
            match("grew", e.grew, d[GREW_BIT]);
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_PAD;
    logic [FIELD_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // rect_width, rect_height
    logic [0:0]             s_tuser   = '0;   // opcode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // pos_x, pos_y, atlas_w, atlas_h,
                                              // extent_w, extent_h, grew
    logic [0:0]             m_tuser;          // ok

    bit           calm = 1'b0;   // no stalls on either side while set
    shelf_tracker tracker = new();

    shelf_atlas_rect_allocator #(.MAX_SIDE(ATLAS_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // result side: check the transfer seen at this edge, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.verify_result(m_tuser[0], m_tdata);
        m_tready <= calm || ($urandom_range(99) >= 9);
    end

    function automatic request_t req(logic op, int unsigned w, int unsigned h);
        request_t r;
        r.op = op;
        r.w  = w[FIELD_W-1:0];
        r.h  = h[FIELD_W-1:0];
        return r;
    endfunction

    function automatic int unsigned rand_side();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(120);
        else if (pick < 90)
            return $urandom_range(600);
        else if (pick < 98)
            return $urandom_range(3000);
        return $urandom_range(ATLAS_MAX);
    endfunction

    // mostly well-formed allocates, a few clears and full-range noise
    function automatic request_t rand_request();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 2)
            return req(OP_CLEAR, $urandom_range(32767), $urandom_range(32767));
        else if (pick < 5)
            return req(OP_ALLOC, $urandom_range(32767), $urandom_range(32767));
        return req(OP_ALLOC, rand_side(), rand_side());
    endfunction

    task automatic send_request(request_t r);
        while (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {{(S_TDATA_W - 2*FIELD_W){1'b0}}, r.h, r.w};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.log_request(r.op, r.w, r.h);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_atlas_regs(int unsigned p, int unsigned s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAD;
        cfg_wdata <= FIELD_W'(p);
        @(posedge clk);
        cfg_index <= CFG_INIT;
        cfg_wdata <= FIELD_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_regs(p, s);
    endtask

    initial
    begin
        int unsigned phase_pad[PHASES];
        int unsigned phase_side[PHASES];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: pad 1, side 1024
        send_request(req(OP_CLEAR, 32767, 32767));
        send_request(req(OP_ALLOC, 0, 0));
        send_request(req(OP_ALLOC, 100, 50));
        send_request(req(OP_ALLOC, 2000, 10));       // wider than the atlas
        send_request(req(OP_ALLOC, 16382, 16382));   // padded box exactly at the limit
        send_request(req(OP_ALLOC, 16383, 1));       // oversize after padding
        send_request(req(OP_ALLOC, 32767, 32767));
        send_request(req(OP_ALLOC, 1, 32767));
        send_request(req(OP_CLEAR, 0, 0));
        settle();

        set_atlas_regs(0, 1);
        send_request(req(OP_ALLOC, 0, 5));           // empty padded box
        send_request(req(OP_ALLOC, 5, 0));
        send_request(req(OP_ALLOC, 1, 1));
        send_request(req(OP_ALLOC, 1, 1));           // new shelf, height grows
        send_request(req(OP_ALLOC, 3, 1));
        send_request(req(OP_ALLOC, 16384, 16384));
        send_request(req(OP_CLEAR, 0, 0));
        send_request(req(OP_ALLOC, 16384, 16384));
        send_request(req(OP_ALLOC, 1, 1));           // no room left below
        settle();

        set_atlas_regs(15, 16384);
        send_request(req(OP_ALLOC, 0, 0));
        send_request(req(OP_ALLOC, 16354, 1));
        send_request(req(OP_ALLOC, 16355, 1));
        send_request(req(OP_ALLOC, 7, 9));
        settle();

        phase_pad  = '{1, 0, 15, 7, 0, 2};
        phase_side = '{1024, 1, 16384, 300, 0, 64};
        phase_pad[4]  = $urandom_range(15);
        phase_side[4] = $urandom_range(16384, 1);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_atlas_regs(phase_pad[ph], phase_side[ph]);
            calm = (ph == 2);
            for (int i = 0; i < PER_PHASE; i++)
                send_request(rand_request());
            settle();
        end
        calm = 1'b0;

        repeat (20) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
